FILE: src/r3kie_pkg.sv
// shared types and codes for the r3000a integer execute core
// request and response payloads, status and size codes, opcode and function codes
// no dependencies
package r3kie_pkg;

   localparam int unsigned XLEN     = 32;
   localparam int unsigned CNT_W    = 64;
   localparam int unsigned REG_AW   = 5;

   typedef enum logic [2:0] {
      ST_DONE   = 3'd0,
      ST_LOAD   = 3'd1,
      ST_STORE  = 3'd2,
      ST_BRANCH = 3'd3,
      ST_UNSUP  = 3'd4,
      ST_UNEXP  = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      SZ_BYTE = 2'd0,
      SZ_HALF = 2'd1,
      SZ_WORD = 2'd2
   } mem_size_type;

   // primary opcodes
   localparam logic [5:0] OP_SPECIAL = 6'h00;
   localparam logic [5:0] OP_BEQ     = 6'h04;
   localparam logic [5:0] OP_BNE     = 6'h05;
   localparam logic [5:0] OP_ADDI    = 6'h08;
   localparam logic [5:0] OP_ADDIU   = 6'h09;
   localparam logic [5:0] OP_SLTI    = 6'h0a;
   localparam logic [5:0] OP_SLTIU   = 6'h0b;
   localparam logic [5:0] OP_ANDI    = 6'h0c;
   localparam logic [5:0] OP_ORI     = 6'h0d;
   localparam logic [5:0] OP_XORI    = 6'h0e;
   localparam logic [5:0] OP_LUI     = 6'h0f;
   localparam logic [5:0] OP_LB      = 6'h20;
   localparam logic [5:0] OP_LH      = 6'h21;
   localparam logic [5:0] OP_LW      = 6'h23;
   localparam logic [5:0] OP_LBU     = 6'h24;
   localparam logic [5:0] OP_LHU     = 6'h25;
   localparam logic [5:0] OP_SB      = 6'h28;
   localparam logic [5:0] OP_SH      = 6'h29;
   localparam logic [5:0] OP_SW      = 6'h2b;

   // special function codes
   localparam logic [5:0] FN_SLL  = 6'h00;
   localparam logic [5:0] FN_SRL  = 6'h02;
   localparam logic [5:0] FN_SRA  = 6'h03;
   localparam logic [5:0] FN_SLLV = 6'h04;
   localparam logic [5:0] FN_SRLV = 6'h06;
   localparam logic [5:0] FN_SRAV = 6'h07;
   localparam logic [5:0] FN_MFHI = 6'h10;
   localparam logic [5:0] FN_MTHI = 6'h11;
   localparam logic [5:0] FN_MFLO = 6'h12;
   localparam logic [5:0] FN_MTLO = 6'h13;
   localparam logic [5:0] FN_ADD  = 6'h20;
   localparam logic [5:0] FN_ADDU = 6'h21;
   localparam logic [5:0] FN_SUB  = 6'h22;
   localparam logic [5:0] FN_SUBU = 6'h23;
   localparam logic [5:0] FN_AND  = 6'h24;
   localparam logic [5:0] FN_OR   = 6'h25;
   localparam logic [5:0] FN_XOR  = 6'h26;
   localparam logic [5:0] FN_NOR  = 6'h27;
   localparam logic [5:0] FN_SLT  = 6'h2a;
   localparam logic [5:0] FN_SLTU = 6'h2b;

   // pending load kinds, low three opcode bits
   localparam logic [2:0] LT_LB  = 3'd0;
   localparam logic [2:0] LT_LH  = 3'd1;
   localparam logic [2:0] LT_LBU = 3'd4;
   localparam logic [2:0] LT_LHU = 3'd5;

   typedef struct packed {
      logic        kind;
      logic [31:0] instr;
      logic [31:0] instr_addr;
      logic [31:0] load_data;
   } req_type;

   typedef struct packed {
      status_type   status;
      logic [31:0]  next_pc;
      logic [31:0]  mem_addr;
      mem_size_type mem_size;
      logic [31:0]  store_data;
      logic [63:0]  cycle_count;
   } rsp_type;

   // execute stage outcome: response fields plus state updates
   typedef struct packed {
      status_type          status;
      logic [XLEN-1:0]     next_pc;
      logic [XLEN-1:0]     mem_addr;
      mem_size_type        mem_size;
      logic [XLEN-1:0]     store_data;
      logic                gpr_we;
      logic [REG_AW-1:0]   gpr_waddr;
      logic [XLEN-1:0]     gpr_wdata;
      logic                hi_we;
      logic                lo_we;
      logic                count_inc;
      logic                load_start;
      logic                load_clear;
      logic [REG_AW-1:0]   load_dest;
      logic [2:0]          load_type;
   } ex_type;

endpackage

FILE: src/r3kie_regfile.sv
// general register file, r1..r31, two read ports and one write port
// read data registered at request accept, with bypass of the same-cycle write
// depends on r3kie_pkg
module r3kie_regfile
   import r3kie_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [REG_AW-1:0] ra_addr,
   input  logic [REG_AW-1:0] rb_addr,
   input  logic              we,
   input  logic [REG_AW-1:0] waddr,
   input  logic [XLEN-1:0]   wdata,
   output logic [XLEN-1:0]   ra_data,
   output logic [XLEN-1:0]   rb_data
);

   localparam int unsigned DEPTH = 2 ** REG_AW;

   logic [XLEN-1:0]  mem [DEPTH];
   logic [DEPTH-1:0] vld_ff;
   logic [XLEN-1:0]  rd_a_ff, rd_b_ff, fwd_data_ff;
   logic             vld_a_ff, vld_b_ff, fwd_a_ff, fwd_b_ff;
   logic             wr_ok;

   // r0 is never written, so its valid bit stays low and it reads zero
   assign wr_ok = we && (waddr != '0);

   always_ff @(posedge clock) begin
      if (wr_ok) begin
         mem[waddr] <= wdata;
      end
      if (rd_en) begin
         rd_a_ff     <= mem[ra_addr];
         rd_b_ff     <= mem[rb_addr];
         fwd_data_ff <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff   <= '0;
         vld_a_ff <= 1'b0;
         vld_b_ff <= 1'b0;
         fwd_a_ff <= 1'b0;
         fwd_b_ff <= 1'b0;
      end else begin
         if (wr_ok) begin
            vld_ff[waddr] <= 1'b1;
         end
         if (rd_en) begin
            vld_a_ff <= vld_ff[ra_addr];
            vld_b_ff <= vld_ff[rb_addr];
            fwd_a_ff <= wr_ok && (waddr == ra_addr);
            fwd_b_ff <= wr_ok && (waddr == rb_addr);
         end
      end
   end

   assign ra_data = fwd_a_ff ? fwd_data_ff : (vld_a_ff ? rd_a_ff : '0);
   assign rb_data = fwd_b_ff ? fwd_data_ff : (vld_b_ff ? rd_b_ff : '0);

endmodule

FILE: src/r3kie_alu.sv
// decode and execute of one request against the operand values
// produces the response fields and the register, hi/lo and load state updates
// depends on r3kie_pkg
module r3kie_alu
   import r3kie_pkg::*;
(
   input  req_type           item,
   input  logic [XLEN-1:0]   op_a,
   input  logic [XLEN-1:0]   op_b,
   input  logic [XLEN-1:0]   hi,
   input  logic [XLEN-1:0]   lo,
   input  logic              load_pending,
   input  logic [REG_AW-1:0] load_dest,
   input  logic [2:0]        load_type,
   output ex_type            ex
);

   logic [5:0]        opc, funct;
   logic [REG_AW-1:0] rt, rd, sa;
   logic [XLEN-1:0]   imm_s, imm_u, pc_plus4, br_target, eff_addr, ld_val;
   logic              rd_nz, rt_nz;

   assign opc       = item.instr[31:26];
   assign rt        = item.instr[20:16];
   assign rd        = item.instr[15:11];
   assign sa        = item.instr[10:6];
   assign funct     = item.instr[5:0];
   assign imm_s     = {{16{item.instr[15]}}, item.instr[15:0]};
   assign imm_u     = {16'h0000, item.instr[15:0]};
   assign pc_plus4  = item.instr_addr + 32'd4;
   assign br_target = pc_plus4 + {imm_s[29:0], 2'b00};
   assign eff_addr  = op_a + imm_s;
   assign rd_nz     = (rd != '0);
   assign rt_nz     = (rt != '0);

   always_comb begin
      unique case (load_type)
         LT_LB:   ld_val = {{24{item.load_data[7]}}, item.load_data[7:0]};
         LT_LH:   ld_val = {{16{item.load_data[15]}}, item.load_data[15:0]};
         LT_LBU:  ld_val = {24'h000000, item.load_data[7:0]};
         LT_LHU:  ld_val = {16'h0000, item.load_data[15:0]};
         default: ld_val = item.load_data;
      endcase
   end

   always_comb begin
      ex = '0;
      ex.status    = ST_DONE;
      ex.mem_size  = SZ_BYTE;
      ex.load_dest = rt;
      ex.load_type = opc[2:0];
      ex.mem_addr  = '0;
      if (item.kind) begin
         if (!load_pending) begin
            ex.status = ST_UNEXP;
         end else begin
            ex.gpr_we     = (load_dest != '0);
            ex.gpr_waddr  = load_dest;
            ex.gpr_wdata  = ld_val;
            ex.load_clear = 1'b1;
         end
      end else if (load_pending) begin
         ex.status = ST_UNEXP;
      end else begin
         ex.count_inc = 1'b1;
         ex.next_pc   = pc_plus4;
         ex.gpr_waddr = rt;
         unique case (opc)
            OP_SPECIAL: begin
               ex.gpr_waddr = rd;
               ex.gpr_we    = rd_nz;
               unique case (funct)
                  FN_SLL:  ex.gpr_wdata = op_b << sa;
                  FN_SRL:  ex.gpr_wdata = op_b >> sa;
                  FN_SRA:  ex.gpr_wdata = $unsigned($signed(op_b) >>> sa);
                  FN_SLLV: ex.gpr_wdata = op_b << op_a[4:0];
                  FN_SRLV: ex.gpr_wdata = op_b >> op_a[4:0];
                  FN_SRAV: ex.gpr_wdata = $unsigned($signed(op_b) >>> op_a[4:0]);
                  FN_MFHI: ex.gpr_wdata = hi;
                  FN_MFLO: ex.gpr_wdata = lo;
                  FN_MTHI: begin
                     ex.gpr_we = 1'b0;
                     ex.hi_we  = 1'b1;
                  end
                  FN_MTLO: begin
                     ex.gpr_we = 1'b0;
                     ex.lo_we  = 1'b1;
                  end
                  FN_ADD, FN_ADDU: ex.gpr_wdata = op_a + op_b;
                  FN_SUB, FN_SUBU: ex.gpr_wdata = op_a - op_b;
                  FN_AND:  ex.gpr_wdata = op_a & op_b;
                  FN_OR:   ex.gpr_wdata = op_a | op_b;
                  FN_XOR:  ex.gpr_wdata = op_a ^ op_b;
                  FN_NOR:  ex.gpr_wdata = ~(op_a | op_b);
                  FN_SLT:  ex.gpr_wdata = {31'd0, $signed(op_a) < $signed(op_b)};
                  FN_SLTU: ex.gpr_wdata = {31'd0, op_a < op_b};
                  default: begin
                     ex.gpr_we = 1'b0;
                     ex.status = ST_UNSUP;
                  end
               endcase
            end
            OP_BEQ, OP_BNE: begin
               // beq takes on equal, bne on not equal
               if ((opc == OP_BEQ) == (op_a == op_b)) begin
                  ex.status  = ST_BRANCH;
                  ex.next_pc = br_target;
               end
            end
            OP_ADDI, OP_ADDIU: begin
               ex.gpr_we    = rt_nz;
               ex.gpr_wdata = eff_addr;
            end
            OP_SLTI: begin
               ex.gpr_we    = rt_nz;
               ex.gpr_wdata = {31'd0, $signed(op_a) < $signed(imm_s)};
            end
            OP_SLTIU: begin
               ex.gpr_we    = rt_nz;
               ex.gpr_wdata = {31'd0, op_a < imm_s};
            end
            OP_ANDI: begin
               ex.gpr_we    = rt_nz;
               ex.gpr_wdata = op_a & imm_u;
            end
            OP_ORI: begin
               ex.gpr_we    = rt_nz;
               ex.gpr_wdata = op_a | imm_u;
            end
            OP_XORI: begin
               ex.gpr_we    = rt_nz;
               ex.gpr_wdata = op_a ^ imm_u;
            end
            OP_LUI: begin
               ex.gpr_we    = rt_nz;
               ex.gpr_wdata = {item.instr[15:0], 16'h0000};
            end
            OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU: begin
               ex.status     = ST_LOAD;
               ex.mem_addr   = eff_addr;
               ex.load_start = 1'b1;
               unique case (opc[1:0])
                  2'b00:   ex.mem_size = SZ_BYTE;
                  2'b01:   ex.mem_size = SZ_HALF;
                  default: ex.mem_size = SZ_WORD;
               endcase
            end
            OP_SB, OP_SH, OP_SW: begin
               ex.status     = ST_STORE;
               ex.mem_addr   = eff_addr;
               ex.store_data = op_b;
               unique case (opc[1:0])
                  2'b00:   ex.mem_size = SZ_BYTE;
                  2'b01:   ex.mem_size = SZ_HALF;
                  default: ex.mem_size = SZ_WORD;
               endcase
            end
            default: ex.status = ST_UNSUP;
         endcase
      end
   end

endmodule

FILE: src/r3kie_top_unused_guard.sv
// small response output stage: holds one finished response until taken
// keeps rsp_valid a pure register output so it never depends on rsp_stall
// depends on r3kie_pkg
module r3kie_rsp_stage
   import r3kie_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  rsp_type load_data,
   input  logic    rsp_stall,
   output logic    free,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   logic    vld_ff, vld_in;
   rsp_type data_ff;

   assign free   = !vld_ff || !rsp_stall;
   assign vld_in = load || (vld_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = vld_ff;
   assign rsp_data  = data_ff;

endmodule

FILE: src/r3000a_integer_execute_core.sv
// r3000a integer execute core: request register, execute logic, response register.
// One request is accepted per clock while req_stall is low; its response passes through
// the request register, then the response register. The register file is
// read as the request is captured; the write of the instruction ahead, retired in that
// same clock, is bypassed into the read, so back-to-back dependent instructions run at
// one per clock while nothing stalls. HI, LO, the load-pending state and the 64-bit
// counter update as the request leaves the request register. The block stalls only
// when both the request and response registers are full and the downstream side stalls.
// depends on r3kie_pkg, r3kie_regfile, r3kie_alu, r3kie_rsp_stage
module r3000a_integer_execute_core
   import r3kie_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic              in_vld_ff, in_vld_in;
   req_type           in_ff;
   logic              accept, advance, out_free;
   logic [XLEN-1:0]   op_a, op_b;
   logic [XLEN-1:0]   hi_ff, lo_ff;
   logic              load_pend_ff;
   logic [REG_AW-1:0] load_dest_ff;
   logic [2:0]        load_type_ff;
   logic [CNT_W-1:0]  count_ff, count_in;
   ex_type            ex;
   rsp_type           rsp_next;

   assign advance   = in_vld_ff && out_free;
   assign req_stall = in_vld_ff && !out_free;
   assign accept    = req_valid && !req_stall;
   assign in_vld_in = accept || (in_vld_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_ff <= req_data;
      end
   end

   r3kie_regfile u_regfile (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .ra_addr (req_data.instr[25:21]),
      .rb_addr (req_data.instr[20:16]),
      .we      (advance && ex.gpr_we),
      .waddr   (ex.gpr_waddr),
      .wdata   (ex.gpr_wdata),
      .ra_data (op_a),
      .rb_data (op_b)
   );

   r3kie_alu u_alu (
      .item         (in_ff),
      .op_a         (op_a),
      .op_b         (op_b),
      .hi           (hi_ff),
      .lo           (lo_ff),
      .load_pending (load_pend_ff),
      .load_dest    (load_dest_ff),
      .load_type    (load_type_ff),
      .ex           (ex)
   );

   assign count_in = count_ff + {{(CNT_W-1){1'b0}}, ex.count_inc};

   always_ff @(posedge clock) begin
      if (reset) begin
         hi_ff        <= '0;
         lo_ff        <= '0;
         load_pend_ff <= 1'b0;
         load_dest_ff <= '0;
         load_type_ff <= '0;
         count_ff     <= '0;
      end else if (advance) begin
         count_ff <= count_in;
         if (ex.hi_we) begin
            hi_ff <= op_a;
         end
         if (ex.lo_we) begin
            lo_ff <= op_a;
         end
         if (ex.load_start) begin
            load_pend_ff <= 1'b1;
            load_dest_ff <= ex.load_dest;
            load_type_ff <= ex.load_type;
         end else if (ex.load_clear) begin
            load_pend_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      rsp_next.status      = ex.status;
      rsp_next.next_pc     = ex.next_pc;
      rsp_next.mem_addr    = ex.mem_addr;
      rsp_next.mem_size    = ex.mem_size;
      rsp_next.store_data  = ex.store_data;
      rsp_next.cycle_count = count_in;
   end

   r3kie_rsp_stage u_rsp_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .load_data (rsp_next),
      .rsp_stall (rsp_stall),
      .free      (out_free),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // counter only moves when a request retires
   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(count_ff))
      else $error("cycle counter moved without a retiring request");

   // an issued load leaves the load pending for the data request
   a_load_pend: assert property (@(posedge clock) disable iff (reset)
      (advance && ex.load_start) |=> load_pend_ff)
      else $error("load issued but not marked pending");

   // every retiring request produces a response
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("retired request produced no response");

endmodule
